// ----- rtl/core/stc_pkg.sv -----
// ----------------------------------------------------------------------------
// Sideband topology classifier package
// Shared types, widths and codes for the sideband topology classifier.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int MaxBands = 4;
  localparam int BandIdxW = 2;
  localparam int CountW   = 3;

  localparam int InDataW  = 208;
  localparam int OutDataW = 80;
  localparam int CfgDataW = 16;

  // Band count that marks a group with more tracks than can be stored.
  localparam logic [CountW-1:0] CountOver = 3'd5;

  // Sideband orders used for the lowest band of a group.
  localparam logic signed [2:0] OrderM4 = -3'sd4;
  localparam logic signed [2:0] OrderM2 = -3'sd2;
  localparam logic signed [2:0] Order0  = 3'sd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INSERT,
    ST_DECIDE,
    ST_THR_MUL,
    ST_THR_CMP,
    ST_LOAD,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_ROUND,
    ST_SUM,
    ST_EMIT
  } stc_state_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_ZERO_POWER = 2'd1,
    STATUS_TOO_MANY   = 2'd2,
    STATUS_MIXED_SEQ  = 2'd3
  } stc_status_t;

  // The carrier sits where the order reaches zero, two orders per band.
  function automatic logic [BandIdxW-1:0] carrier_index(logic signed [2:0] first_order);
    logic [BandIdxW-1:0] idx;
    case (first_order)
      OrderM4: idx = 2'd2;
      OrderM2: idx = 2'd1;
      default: idx = 2'd0;
    endcase
    return idx;
  endfunction

endpackage

// ----- rtl/core/sideband_topology_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// Sideband topology classifier
// Sorts up to four tracks of a group and emits their sideband orders together
// with the carrier frequency at the earliest start time.
// ----------------------------------------------------------------------------
// Usage:
// Each word on the in_ channel carries one track; in_tlast marks the final
// track of a group. Tracks are kept sorted by start frequency with an
// insertion walk that moves one stored band per cycle, so a stored track
// occupies the block until its slot is found, while a surplus track (fifth
// or later) is only counted. in_tready is high only while the block is idle.
// On the final track the sequencer checks the group, runs the power test
// (only for two or three bands) and evaluates the carrier line on the one
// shared 40 x 16 multiplier in two halves followed by rounding and
// saturation. It then presents one result word per band on the out_ channel,
// or a single status word on an error; out_tlast marks the last one. A stalled
// receiver simply holds the block in its output state; the result word stays
// stable until taken. After the final result the group state returns to
// empty. The cfg_ word writes the power threshold and is always taken. A
// synchronous reset clears the group and the threshold.
module sideband_topology_classifier_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // track_id, sequence_id, start_frequency, total_power, start_time, slope,
  // intercept (lowest bits first)
  input  logic [stc_pkg::InDataW-1:0]   in_tdata,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // band_track, band_sequence, band_order, cyclotron_start_freq, status,
  // three zero bits (lowest bits first)
  output logic [stc_pkg::OutDataW-1:0]  out_tdata,
  output logic                          out_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [stc_pkg::CfgDataW-1:0]  cfg_data
);
  import stc_pkg::*;

  // Sorted band store.
  logic [15:0] trk_r   [MaxBands];
  logic [15:0] seq_r   [MaxBands];
  logic [31:0] freq_r  [MaxBands];
  logic [31:0] pow_r   [MaxBands];
  logic [39:0] slope_r [MaxBands];
  logic [39:0] icpt_r  [MaxBands];

  // Captured input word.
  logic [15:0] item_trk_r;
  logic [15:0] item_seq_r;
  logic [31:0] item_freq_r;
  logic [31:0] item_pow_r;
  logic [39:0] item_slope_r;
  logic [39:0] item_icpt_r;
  logic        item_last_r;

  stc_state_t             state_r, state_nxt;
  logic [CountW-1:0]      count_r;
  logic [BandIdxW-1:0]    ins_idx_r;
  logic [BandIdxW-1:0]    emit_idx_r;
  logic [31:0]            peak_r;
  logic [31:0]            earliest_r;
  logic [CfgDataW-1:0]    thresh_r;
  logic signed [2:0]      first_order_r;
  stc_status_t            status_r;
  logic [39:0]            mag_r;
  logic                   neg_r;
  logic [39:0]            line_icpt_r;
  logic [55:0]            prod_r;
  logic [71:0]            acc_r;
  logic [48:0]            p_r;
  logic [39:0]            carrier_freq_r;

  // Single read port into the band store.
  logic [BandIdxW-1:0] rd_idx;
  logic [15:0]         rd_trk;
  logic [31:0]         rd_freq;
  logic [31:0]         rd_pow;
  logic [39:0]         rd_slope;
  logic [39:0]         rd_icpt;

  // Shared multiplier.
  logic [39:0] mult_a;
  logic [15:0] mult_b;
  logic [55:0] product;

  logic        in_fire;
  logic        out_fire;
  logic        ins_place;
  logic        mixed_seq;
  logic        two_or_three;
  stc_status_t dec_status;
  logic        top_strong;
  logic        emit_last;
  logic        is_error;
  logic [48:0] q_ext;
  logic [49:0] line_sum;
  logic [39:0] line_sat;
  logic [2:0]  out_order;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign cfg_ready = 1'b1;

  assign rd_trk   = trk_r[rd_idx];
  assign rd_freq  = freq_r[rd_idx];
  assign rd_pow   = pow_r[rd_idx];
  assign rd_slope = slope_r[rd_idx];
  assign rd_icpt  = icpt_r[rd_idx];

  assign product = mult_a * mult_b;

  // Stop the walk at the bottom or behind a band of lower or equal frequency,
  // which keeps equal frequencies in arrival order.
  assign ins_place = (ins_idx_r == '0) || (rd_freq <= item_freq_r);

  assign two_or_three = count_r inside {3'd2, 3'd3};

  always_comb begin
    mixed_seq = 1'b0;
    for (int i = 1; i < MaxBands; i++) begin
      if ((CountW'(i) < count_r) && (seq_r[i] != seq_r[0])) begin
        mixed_seq = 1'b1;
      end
    end
  end

  always_comb begin
    if (count_r == CountOver) begin
      dec_status = STATUS_TOO_MANY;
    end else if (two_or_three && (peak_r == '0)) begin
      dec_status = STATUS_ZERO_POWER;
    end else if (mixed_seq) begin
      dec_status = STATUS_MIXED_SEQ;
    end else begin
      dec_status = STATUS_OK;
    end
  end

  // Top band power * 65536 against threshold * peak power.
  assign top_strong = {rd_pow, 16'h0000} > prod_r[47:0];

  // Carrier line: round toward minus infinity, add intercept, saturate.
  assign q_ext    = {1'b0, acc_r[71:24]};
  assign line_sum = {p_r[48], p_r} + {{10{line_icpt_r[39]}}, line_icpt_r};
  always_comb begin
    if (line_sum[49:39] == '0 || line_sum[49:39] == '1) begin
      line_sat = line_sum[39:0];
    end else if (line_sum[49]) begin
      line_sat = {1'b1, 39'h0};
    end else begin
      line_sat = {1'b0, {39{1'b1}}};
    end
  end

  assign is_error  = (status_r != STATUS_OK);
  assign emit_last = is_error || ({1'b0, emit_idx_r} == count_r - 3'd1);
  assign out_order = first_order_r + {emit_idx_r, 1'b0};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (count_r < CountW'(MaxBands)) begin
            state_nxt = ST_INSERT;
          end else if (in_tlast) begin
            state_nxt = ST_DECIDE;
          end
        end
      end
      ST_INSERT: begin
        if (ins_place) begin
          state_nxt = item_last_r ? ST_DECIDE : ST_IDLE;
        end
      end
      ST_DECIDE: begin
        if (dec_status != STATUS_OK) begin
          state_nxt = ST_EMIT;
        end else if (two_or_three) begin
          state_nxt = ST_THR_MUL;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      ST_THR_MUL: state_nxt = ST_THR_CMP;
      ST_THR_CMP: state_nxt = ST_LOAD;
      ST_LOAD:    state_nxt = ST_MUL_LO;
      ST_MUL_LO:  state_nxt = ST_MUL_HI;
      ST_MUL_HI:  state_nxt = ST_ACC;
      ST_ACC:     state_nxt = ST_ROUND;
      ST_ROUND:   state_nxt = ST_SUM;
      ST_SUM:     state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_fire && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshakes, read address and multiplier operands.
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    rd_idx     = '0;
    mult_a     = mag_r;
    mult_b     = earliest_r[15:0];
    case (state_r)
      ST_IDLE:    in_tready = 1'b1;
      ST_INSERT:  rd_idx = ins_idx_r - 2'd1;
      ST_THR_MUL: begin
        mult_a = {8'h00, peak_r};
        mult_b = thresh_r;
      end
      ST_THR_CMP: rd_idx = count_r[BandIdxW-1:0] - 2'd1;
      ST_LOAD:    rd_idx = carrier_index(first_order_r);
      ST_MUL_HI:  mult_b = earliest_r[31:16];
      ST_EMIT: begin
        out_tvalid = 1'b1;
        rd_idx     = emit_idx_r;
      end
      default: begin
        rd_idx = '0;
      end
    endcase
  end

  assign out_tdata = {3'b000,
                      status_r,
                      is_error ? 40'h0 : carrier_freq_r,
                      is_error ? 3'b000 : out_order,
                      seq_r[0],
                      is_error ? 16'h0000 : rd_trk};
  assign out_tlast = emit_last;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      peak_r     <= '0;
      earliest_r <= '1;
      thresh_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        thresh_r <= cfg_data;
      end
      if (in_fire) begin
        if (in_tdata[95:64] > peak_r) begin
          peak_r <= in_tdata[95:64];
        end
        if (in_tdata[127:96] < earliest_r) begin
          earliest_r <= in_tdata[127:96];
        end
        if (count_r >= CountW'(MaxBands)) begin
          count_r <= CountOver;
        end
      end
      if (state_r == ST_INSERT && ins_place) begin
        count_r <= count_r + 3'd1;
      end
      if (out_fire && emit_last) begin
        count_r    <= '0;
        peak_r     <= '0;
        earliest_r <= '1;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    prod_r <= product;
    case (state_r)
      ST_IDLE: begin
        item_trk_r   <= in_tdata[15:0];
        item_seq_r   <= in_tdata[31:16];
        item_freq_r  <= in_tdata[63:32];
        item_pow_r   <= in_tdata[95:64];
        item_slope_r <= in_tdata[167:128];
        item_icpt_r  <= in_tdata[207:168];
        item_last_r  <= in_tlast;
        ins_idx_r    <= count_r[BandIdxW-1:0];
      end
      ST_INSERT: begin
        if (ins_place) begin
          trk_r[ins_idx_r]   <= item_trk_r;
          seq_r[ins_idx_r]   <= item_seq_r;
          freq_r[ins_idx_r]  <= item_freq_r;
          pow_r[ins_idx_r]   <= item_pow_r;
          slope_r[ins_idx_r] <= item_slope_r;
          icpt_r[ins_idx_r]  <= item_icpt_r;
        end else begin
          // Shift the higher band up one slot and keep walking down.
          trk_r[ins_idx_r]   <= rd_trk;
          seq_r[ins_idx_r]   <= seq_r[rd_idx];
          freq_r[ins_idx_r]  <= rd_freq;
          pow_r[ins_idx_r]   <= rd_pow;
          slope_r[ins_idx_r] <= rd_slope;
          icpt_r[ins_idx_r]  <= rd_icpt;
          ins_idx_r          <= ins_idx_r - 2'd1;
        end
      end
      ST_DECIDE: begin
        status_r      <= dec_status;
        emit_idx_r    <= '0;
        first_order_r <= (count_r == 3'd4) ? OrderM4 : Order0;
      end
      ST_THR_CMP: begin
        if (count_r == 3'd2) begin
          first_order_r <= top_strong ? OrderM2 : Order0;
        end else begin
          first_order_r <= top_strong ? OrderM4 : OrderM2;
        end
      end
      ST_LOAD: begin
        neg_r       <= rd_slope[39];
        mag_r       <= rd_slope[39] ? (~rd_slope + 40'd1) : rd_slope;
        line_icpt_r <= rd_icpt;
      end
      ST_MUL_HI: acc_r <= {16'h0000, prod_r};
      ST_ACC:    acc_r <= acc_r + {prod_r, 16'h0000};
      ST_ROUND: begin
        // Negative products round down: -q when exact, -q - 1 otherwise.
        if (!neg_r) begin
          p_r <= q_ext;
        end else if (acc_r[23:0] != '0) begin
          p_r <= ~q_ext;
        end else begin
          p_r <= ~q_ext + 49'd1;
        end
      end
      ST_SUM: carrier_freq_r <= line_sat;
      ST_EMIT: begin
        if (out_fire && !emit_last) begin
          emit_idx_r <= emit_idx_r + 2'd1;
        end
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sideband topology classifier testbench
// Feeds groups of tracks into the classifier, predicts the band orders, the
// carrier frequency and the status of every group, and checks each result
// word against the oldest prediction while both sides idle and stall.
// ----------------------------------------------------------------------------
module tb;
  import stc_pkg::*;

  localparam logic signed [2:0]  OrderP2      = 3'sd2;
  localparam logic signed [79:0] FreqMax      = 80'sd549755813887;
  localparam logic signed [79:0] FreqMin      = -80'sd549755813888;
  localparam int                 RandomTracks = 90;
  // Cycles that cover the longest insertion walk plus the power test, the
  // carrier arithmetic and the first output word.
  localparam int                 SettleCycles = 24;
  localparam int                 StallLimit   = 2000;

  // One track word as it travels on in_tdata, first field in the lowest bits.
  typedef struct packed {
    logic [39:0] intercept;
    logic [39:0] slope;
    logic [31:0] start_time;
    logic [31:0] total_power;
    logic [31:0] start_freq;
    logic [15:0] sequence_id;
    logic [15:0] track_id;
  } track_t;

  // One result word as it travels on out_tdata, first field in the lowest bits.
  typedef struct packed {
    logic [2:0]         pad;
    stc_status_t        status;
    logic [39:0]        start_freq;
    logic signed [2:0]  order;
    logic [15:0]        sequence_id;
    logic [15:0]        track_id;
  } band_t;

  typedef struct {
    band_t word;
    bit    last;
  } band_result_t;

  // Keeps a private copy of the group state and the threshold, works out the
  // band words that each final track releases and checks the words that come
  // out against them in order.
  class band_ledger;
    logic [15:0]  power_thresh;
    track_t       grp_band[MaxBands];
    int unsigned  grp_count;
    logic [31:0]  grp_peak;
    logic [31:0]  grp_earliest;
    band_result_t pending_bands[$];
    int unsigned  failures;

    function new();
      power_thresh = '0;
      failures     = 0;
      clear_group();
    endfunction

    function void clear_group();
      grp_count    = 0;
      grp_peak     = '0;
      grp_earliest = '1;
    endfunction

    function void note_track(track_t trk, bit last_band);
      int unsigned        pos;
      int unsigned        n;
      int unsigned        carrier;
      logic signed [2:0]  orders[MaxBands];
      stc_status_t        status;
      logic [63:0]        top_scaled;
      logic [63:0]        thr_scaled;
      logic signed [79:0] prod;
      logic signed [79:0] carrier_hz;
      band_result_t       res;
      bit                 top_strong;

      if (trk.total_power > grp_peak) grp_peak = trk.total_power;
      if (trk.start_time < grp_earliest) grp_earliest = trk.start_time;

      // Insertion after every stored band with an equal or lower start
      // frequency keeps ties in arrival order.
      if (grp_count < MaxBands) begin
        pos = 0;
        for (int i = 0; i < grp_count; i++)
          if (grp_band[i].start_freq <= trk.start_freq) pos = i + 1;
        for (int i = grp_count; i > pos; i--)
          grp_band[i] = grp_band[i-1];
        grp_band[pos] = trk;
        grp_count++;
      end else begin
        grp_count = 32'(CountOver);
      end

      if (!last_band) return;

      n       = grp_count;
      status  = STATUS_OK;
      carrier = 0;
      foreach (orders[i]) orders[i] = Order0;

      if (n > MaxBands) begin
        status = STATUS_TOO_MANY;
      end else if (n == MaxBands) begin
        orders  = '{OrderM4, OrderM2, Order0, OrderP2};
        carrier = 2;
      end else if (n > 1) begin
        if (grp_peak == 0) begin
          status = STATUS_ZERO_POWER;
        end else begin
          // Top band power against threshold / 65536 times the peak power,
          // both sides scaled by 65536 so no division is needed.
          top_scaled = {16'd0, grp_band[n-1].total_power, 16'd0};
          thr_scaled = {48'd0, power_thresh} * {32'd0, grp_peak};
          top_strong = top_scaled > thr_scaled;
          if (n == 2) begin
            if (top_strong) begin
              orders[0] = OrderM2; orders[1] = Order0; carrier = 1;
            end else begin
              orders[0] = Order0; orders[1] = OrderP2; carrier = 0;
            end
          end else if (top_strong) begin
            orders[0] = OrderM4; orders[1] = OrderM2; orders[2] = Order0; carrier = 2;
          end else begin
            orders[0] = OrderM2; orders[1] = Order0; orders[2] = OrderP2; carrier = 1;
          end
        end
      end

      if (status == STATUS_OK)
        for (int i = 1; i < n; i++)
          if (grp_band[i].sequence_id != grp_band[0].sequence_id) status = STATUS_MIXED_SEQ;

      if (status != STATUS_OK) begin
        res.word             = '0;
        res.word.sequence_id = grp_band[0].sequence_id;
        res.word.status      = status;
        res.last             = 1'b1;
        pending_bands        = {pending_bands, res};
      end else begin
        // Carrier line at the earliest start: the arithmetic shift floors
        // toward minus infinity, then the sum saturates to 40 bits.
        prod = $signed({{40{grp_band[carrier].slope[39]}}, grp_band[carrier].slope}) *
               $signed({48'd0, grp_earliest});
        carrier_hz = (prod >>> 24) +
                     $signed({{40{grp_band[carrier].intercept[39]}},
                              grp_band[carrier].intercept});
        if (carrier_hz > FreqMax) carrier_hz = FreqMax;
        else if (carrier_hz < FreqMin) carrier_hz = FreqMin;
        for (int i = 0; i < n; i++) begin
          res.word             = '0;
          res.word.track_id    = grp_band[i].track_id;
          res.word.sequence_id = grp_band[0].sequence_id;
          res.word.order       = orders[i];
          res.word.start_freq  = carrier_hz[39:0];
          res.word.status      = STATUS_OK;
          res.last             = (i == n - 1);
          pending_bands        = {pending_bands, res};
        end
      end
      clear_group();
    endfunction

    function void compare_field(string name, logic [39:0] want, logic [39:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t %s: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_band(band_t got, bit got_last);
      band_result_t want;
      if (pending_bands.size() == 0) begin
        failures++;
        $display("%0t result word: expected none, actual %h last %b", $time, got, got_last);
        return;
      end
      want = pending_bands.pop_front();
      compare_field("band_track", 40'(want.word.track_id), 40'(got.track_id));
      compare_field("band_sequence", 40'(want.word.sequence_id), 40'(got.sequence_id));
      compare_field("band_order", 40'(want.word.order), 40'(got.order));
      compare_field("cyclotron_start_freq", want.word.start_freq, got.start_freq);
      compare_field("status", 40'(want.word.status), 40'(got.status));
      compare_field("last", 40'(want.last), 40'(got_last));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;   // track_id, sequence_id, start_frequency,
                                   // total_power, start_time, slope, intercept
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;  // band_track, band_sequence, band_order,
                                   // cyclotron_start_freq, status, zero fill
  logic                out_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgDataW-1:0] cfg_data;

  band_ledger  ledger = new();
  bit          in_calm;
  int unsigned random_tracks;

  sideband_topology_classifier_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic track_t make_track(logic [15:0] track_id, logic [15:0] seq,
                                        logic [31:0] freq, logic [31:0] power,
                                        logic [31:0] start, logic [39:0] slope,
                                        logic [39:0] icpt);
    track_t trk;
    trk.track_id    = track_id;
    trk.sequence_id = seq;
    trk.start_freq  = freq;
    trk.total_power = power;
    trk.start_time  = start;
    trk.slope       = slope;
    trk.intercept   = icpt;
    return trk;
  endfunction

  // Offers one track word after a random gap and records it once taken.
  // The gap is skipped while the sender is in a calm stretch.
  task automatic send_track(input track_t trk, input bit last_band);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= trk;
    in_tlast  <= last_band;
    do @(posedge clk); while (in_tready !== 1'b1);
    ledger.note_track(trk, last_band);
  endtask

  // Lets every predicted word come out, then gives the block time to settle
  // back to idle before the threshold may change.
  task automatic wait_drained();
    @(negedge clk) in_tvalid <= 1'b0;
    while (ledger.pending_bands.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    ledger.power_thresh = value;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // One random group. Most groups are well formed with one to four bands and
  // a shared sequence; a few carry too many bands, a foreign sequence or no
  // power at all. Clustered start frequencies make ties common.
  task automatic random_group();
    int          n;
    int          pick;
    logic [15:0] seq;
    bit          mixed;
    bit          dead_power;
    bit          few_freqs;
    logic [63:0] wide;
    track_t      trk;

    pick       = $urandom_range(0, 19);
    n          = (pick < 18) ? 1 + pick % 4 : 5 + pick % 2;
    seq        = 16'($urandom_range(0, 65535));
    mixed      = ($urandom_range(0, 9) == 0);
    dead_power = ($urandom_range(0, 9) == 0);
    few_freqs  = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) in_calm = !in_calm;

    for (int i = 0; i < n; i++) begin
      trk.track_id    = 16'($urandom_range(0, 65535));
      trk.sequence_id = (mixed && i == n - 1) ? seq ^ 16'h0001 : seq;
      trk.start_freq  = few_freqs ? $urandom_range(0, 3) * 1000 : $urandom;
      trk.total_power = dead_power ? 32'd0 :
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom;
      trk.start_time  = $urandom;
      wide            = {$urandom, $urandom};
      trk.slope       = $urandom_range(0, 1) ? wide[39:0] : {{30{wide[9]}}, wide[9:0]};
      wide            = {$urandom, $urandom};
      trk.intercept   = $urandom_range(0, 1) ? wide[39:0] : {{30{wide[19]}}, wide[19:0]};
      send_track(trk, i == n - 1);
      random_tracks++;
    end
  endtask

  // Main sequence: reset, a directed set under the two threshold extremes,
  // then random groups across several threshold settings.
  initial begin
    int phase;

    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_calm       = 1'b0;
    random_tracks = 0;
    phase         = 0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    write_threshold(16'h0000);

    // A single band whose carrier line overflows the top of the range.
    send_track(make_track(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          40'h7F_FFFF_FFFF, 40'h7F_FFFF_FFFF), 1'b1);
    // A single band with no power, overflowing the bottom of the range.
    send_track(make_track(16'h0000, 16'h0000, 32'h0, 32'h0, 32'hFFFF_FFFF,
                          40'h80_0000_0000, 40'h80_0000_0000), 1'b1);
    // A small negative slope whose fraction must round toward minus infinity.
    send_track(make_track(16'h0001, 16'h0002, 32'd5, 32'd1, 32'd1,
                          40'hFF_FFFF_FFFD, 40'h0), 1'b1);
    // Four bands in descending order with a tie in the middle.
    send_track(make_track(16'd10, 16'd7, 32'd50, 32'd4, 32'h0300_0000, 40'd100, 40'd7), 1'b0);
    send_track(make_track(16'd11, 16'd7, 32'd30, 32'd9, 32'h0200_0000, 40'd200, 40'd5), 1'b0);
    send_track(make_track(16'd12, 16'd7, 32'd30, 32'd2, 32'h0180_0000,
                          40'hFF_FFFF_FC00, 40'd1_000_000), 1'b0);
    send_track(make_track(16'd13, 16'd7, 32'd10, 32'd1, 32'h0400_0000, 40'd300, 40'd3), 1'b1);
    // Two bands: any power on the top band is strong at a zero threshold.
    send_track(make_track(16'd20, 16'd8, 32'd100, 32'd0, 32'd99, 40'd11, 40'd12), 1'b0);
    send_track(make_track(16'd21, 16'd8, 32'd200, 32'd5, 32'd77, 40'd13, 40'd14), 1'b1);
    // Two bands with a silent top band, which stays weak.
    send_track(make_track(16'd22, 16'd9, 32'd200, 32'd0, 32'd50, 40'd15, 40'd16), 1'b0);
    send_track(make_track(16'd23, 16'd9, 32'd100, 32'd9, 32'd60, 40'd17, 40'd18), 1'b1);
    // Three silent bands with mixed sequences: zero power takes priority.
    send_track(make_track(16'd30, 16'd1, 32'd3, 32'd0, 32'd1, 40'd1, 40'd1), 1'b0);
    send_track(make_track(16'd31, 16'd2, 32'd2, 32'd0, 32'd1, 40'd1, 40'd1), 1'b0);
    send_track(make_track(16'd32, 16'd3, 32'd1, 32'd0, 32'd1, 40'd1, 40'd1), 1'b1);
    // Two bands from different sequences.
    send_track(make_track(16'd40, 16'd4, 32'd1, 32'd1, 32'd1, 40'd1, 40'd1), 1'b0);
    send_track(make_track(16'd41, 16'd5, 32'd2, 32'd1, 32'd1, 40'd1, 40'd1), 1'b1);
    // Five bands: the surplus one is dropped but its power still counts.
    for (int i = 0; i < 5; i++)
      send_track(make_track(16'(50 + i), 16'd6, 32'd5 - i, 32'd1 + i, 32'd100 - i,
                            40'd1, 40'd1), i == 4);

    wait_drained();
    write_threshold(16'hFFFF);
    // At the highest threshold only a top band carrying the peak is strong.
    send_track(make_track(16'd60, 16'd3, 32'd1, 32'd3, 32'h0100_0000, 40'd1, 40'd1), 1'b0);
    send_track(make_track(16'd61, 16'd3, 32'd2, 32'd1, 32'h0100_0000, 40'd2, 40'd2), 1'b0);
    send_track(make_track(16'd62, 16'd3, 32'd3, 32'd3, 32'h0100_0000, 40'd3, 40'd3), 1'b1);
    send_track(make_track(16'd63, 16'd4, 32'd1, 32'd3, 32'h0080_0000, 40'd4, 40'd4), 1'b0);
    send_track(make_track(16'd64, 16'd4, 32'd2, 32'd1, 32'h0080_0000,
                          40'hFF_FFFF_FFFB, 40'd5), 1'b0);
    send_track(make_track(16'd65, 16'd4, 32'd3, 32'd2, 32'h0080_0000, 40'd6, 40'd6), 1'b1);

    while (random_tracks < RandomTracks) begin
      wait_drained();
      case (phase % 4)
        0:       write_threshold(16'($urandom_range(0, 65535)));
        1:       write_threshold(16'h0000);
        2:       write_threshold(16'hFFFF);
        default: write_threshold(16'h8000);
      endcase
      repeat (4) random_group();
      phase++;
    end

    wait_drained();
    if (ledger.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side. Each word waits a random number of cycles; now and then the
  // receiver goes calm and takes words back to back. Twice it holds off for a
  // long stretch so that the block fills up and stalls its input.
  initial begin
    int stall;
    int taken;
    bit calm;

    out_tready = 1'b0;
    taken      = 0;
    calm       = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken == 20 || taken == 45) stall = 150;
      else stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      ledger.check_band(out_tdata, out_tlast);
      taken++;
      if ($urandom_range(0, 7) == 0) calm = !calm;
    end
  end

  // Watchdog: ends the run once no word has moved on any channel for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
